// ----- hw/rtl/lp_vector_distance_core_defines.svh -----
// Assertion macros shared by the lp_vector_distance_core RTL.
// Depends on nothing; files that assert include it by bare name.
`ifndef LP_VECTOR_DISTANCE_CORE_DEFINES_SVH
`define LP_VECTOR_DISTANCE_CORE_DEFINES_SVH

// Same-cycle implication, clocked on aclk, off while in reset.
`define LPVD_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, clocked on aclk, off while in reset.
`define LPVD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hw/rtl/lpvd_pkg.sv -----
// Shared types, widths and codes for the lp_vector_distance_core.
// No dependencies.
`timescale 1ns / 1ps

package lpvd_pkg;

    localparam int LANES      = 4;
    localparam int MAX_DIMS   = 4096;
    localparam int ELEM_BITS  = 16;

    localparam int LANE_IDX_W = $clog2(LANES);
    localparam int ABS_W      = ELEM_BITS;
    localparam int SQ_W       = 2 * ELEM_BITS;
    localparam int SUM_W      = SQ_W + LANE_IDX_W;
    localparam int ACC_W      = 48;
    localparam int THR_W      = 48;
    localparam int DIST_W     = ACC_W + 1;
    localparam int LEN_W      = 13;
    localparam int GRP_W      = $clog2(MAX_DIMS / LANES);
    localparam int ROOT_W     = ACC_W / 2;
    localparam int ROOT_CNT_W = $clog2(ROOT_W);

    localparam int S_FIELDS_W = 2 * LANES * ELEM_BITS + THR_W;
    localparam int S_TDATA_W  = ((S_FIELDS_W + 7) / 8) * 8;
    localparam int M_TDATA_W  = ((DIST_W + 7) / 8) * 8;

    localparam int CFG_ADDR_W = 1;
    localparam int CFG_DATA_W = LEN_W;
    localparam int MODE_W     = 2;

    localparam logic [CFG_ADDR_W-1:0] REG_MODE   = 1'b0;
    localparam logic [CFG_ADDR_W-1:0] REG_LENGTH = 1'b1;

    localparam logic [LEN_W-1:0] LEN_RESET = LEN_W'(128);
    localparam logic [LEN_W-1:0] LEN_MAX   = LEN_W'(MAX_DIMS);

    typedef enum logic [MODE_W-1:0] {
        MODE_L1   = 2'd0,
        MODE_L2SQ = 2'd1,
        MODE_L2   = 2'd2,
        MODE_MAX  = 2'd3
    } lpvd_mode_t;

    typedef enum logic [1:0] {
        FIN_IDLE,
        FIN_ROOT,
        FIN_HOLD
    } lpvd_fin_state_t;

    // Control that travels alongside the lane values.
    typedef struct packed {
        logic valid;
        logic first;
        logic last;
        logic full;
    } lpvd_item_ctl_t;

    // End-of-vector result handed from the merge stage to the finisher.
    typedef struct packed {
        logic             valid;
        logic             abandoned;
        logic [ACC_W-1:0] value;
    } lpvd_fin_t;

endpackage

// ----- hw/rtl/lp_vector_distance_core.sv -----
// A vector's result passes the lane, merge and finisher registers to the output register;
// in L2 root mode the finisher first runs 24 root iterations. Throughput: one item per
// cycle inside a vector; after the last item input stalls until its result reaches the
// output register. Reset: aresetn synchronous, active low; mode L1, length 128, no vector
// in progress. A config write restarts the vector count.
// Top level: input accept, vector bookkeeping, four lanes, merge and finisher.
`timescale 1ns / 1ps
`include "lp_vector_distance_core_defines.svh"

module lp_vector_distance_core (
    input  logic                                aclk,
    input  logic                                aresetn,
    // config write port
    input  logic                                cfg_wr_en,
    input  logic [lpvd_pkg::CFG_ADDR_W-1:0]     cfg_addr,
    input  logic [lpvd_pkg::CFG_DATA_W-1:0]     cfg_wdata,
    // input words
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // low to high: left_0..left_3, right_0..right_3, threshold
    input  logic [lpvd_pkg::S_TDATA_W-1:0]      s_tdata,
    // result words
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // low to high: distance, zero pad
    output logic [lpvd_pkg::M_TDATA_W-1:0]      m_tdata,
    // bit 0: abandoned
    output logic                                m_tuser
);

    localparam int EB = lpvd_pkg::ELEM_BITS;
    localparam int NL = lpvd_pkg::LANES;
    localparam int THR_LSB = 2 * NL * EB;

    lpvd_pkg::lpvd_mode_t             mode_reg;
    logic [lpvd_pkg::LEN_W-1:0]       len_reg;
    logic [lpvd_pkg::GRP_W-1:0]       grp_cnt_reg;
    logic [lpvd_pkg::THR_W-1:0]       thr_reg;
    logic [lpvd_pkg::ACC_W-1:0]       thr_sq_reg;
    logic                             thr_big_reg;
    lpvd_pkg::lpvd_item_ctl_t         lane_ctl_reg, lane_ctl_next;

    logic [lpvd_pkg::LEN_W-1:0]       len_eff;
    logic [lpvd_pkg::LEN_W-1:0]       len_m1;
    logic [lpvd_pkg::GRP_W-1:0]       items_m1;
    logic                             accept;
    logic                             is_first;
    logic                             is_last;
    logic                             is_full;
    logic [NL-1:0]                    lane_en;
    logic [lpvd_pkg::THR_W-1:0]       s_thr;
    logic [NL-1:0][lpvd_pkg::SQ_W-1:0] lane_val;
    lpvd_pkg::lpvd_fin_t              fin;
    logic                             fin_busy;
    logic                             sq_sel;

    always_comb begin
        if (len_reg == '0) begin
            len_eff = lpvd_pkg::LEN_W'(1);
        end else if (len_reg > lpvd_pkg::LEN_MAX) begin
            len_eff = lpvd_pkg::LEN_MAX;
        end else begin
            len_eff = len_reg;
        end
    end

    assign len_m1   = len_eff - 1'b1;
    assign items_m1 = len_m1[lpvd_pkg::LANE_IDX_W +: lpvd_pkg::GRP_W];
    assign is_first = (grp_cnt_reg == '0);
    assign is_last  = (grp_cnt_reg == items_m1);
    assign is_full  = !is_last || (len_eff[lpvd_pkg::LANE_IDX_W-1:0] == '0);

    always_comb begin
        for (int i = 0; i < NL; i++) begin
            lane_en[i] = is_full
                       || (lpvd_pkg::LANE_IDX_W'(i) < len_eff[lpvd_pkg::LANE_IDX_W-1:0]);
        end
    end

    // Hold off new words while a vector end is still on its way to the output.
    assign s_tready = !(lane_ctl_reg.valid && lane_ctl_reg.last) && !fin.valid && !fin_busy;
    assign accept   = s_tvalid && s_tready;
    assign s_thr    = s_tdata[THR_LSB +: lpvd_pkg::THR_W];
    assign sq_sel   = (mode_reg == lpvd_pkg::MODE_L2SQ) || (mode_reg == lpvd_pkg::MODE_L2);

    always_comb begin
        lane_ctl_next.valid = accept;
        lane_ctl_next.first = is_first;
        lane_ctl_next.last  = is_last;
        lane_ctl_next.full  = is_full;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg     <= lpvd_pkg::MODE_L1;
            len_reg      <= lpvd_pkg::LEN_RESET;
            grp_cnt_reg  <= '0;
            lane_ctl_reg <= '0;
        end else begin
            lane_ctl_reg <= lane_ctl_next;
            if (cfg_wr_en) begin
                case (cfg_addr)
                    lpvd_pkg::REG_MODE: begin
                        mode_reg <= lpvd_pkg::lpvd_mode_t'(cfg_wdata[lpvd_pkg::MODE_W-1:0]);
                    end
                    lpvd_pkg::REG_LENGTH: begin
                        len_reg <= cfg_wdata[lpvd_pkg::LEN_W-1:0];
                    end
                    default: begin
                        len_reg <= len_reg;
                    end
                endcase
                grp_cnt_reg <= '0;
            end else if (accept) begin
                grp_cnt_reg <= is_last ? '0 : grp_cnt_reg + 1'b1;
            end
        end
    end

    // Threshold and its square are sampled on the first word of a vector.
    always_ff @(posedge aclk) begin
        if (accept && is_first) begin
            thr_reg     <= s_thr;
            thr_sq_reg  <= lpvd_pkg::ACC_W'(s_thr[lpvd_pkg::ROOT_W-1:0])
                         * lpvd_pkg::ACC_W'(s_thr[lpvd_pkg::ROOT_W-1:0]);
            thr_big_reg <= |s_thr[lpvd_pkg::THR_W-1:lpvd_pkg::ROOT_W];
        end
    end

    for (genvar g = 0; g < NL; g++) begin : g_lane
        lpvd_lane u_lane (
            .aclk     (aclk),
            .left_in  (s_tdata[g*EB +: EB]),
            .right_in (s_tdata[(NL+g)*EB +: EB]),
            .lane_en  (lane_en[g]),
            .sq_sel   (sq_sel),
            .lane_val (lane_val[g])
        );
    end

    lpvd_merge u_merge (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .lane_val (lane_val),
        .ctl      (lane_ctl_reg),
        .mode     (mode_reg),
        .thr      (thr_reg),
        .thr_sq   (thr_sq_reg),
        .thr_big  (thr_big_reg),
        .fin      (fin)
    );

    lpvd_finish u_finish (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .fin      (fin),
        .mode     (mode_reg),
        .thr      (thr_reg),
        .busy     (fin_busy),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    `LPVD_ASSERT_NEXT(a_last_stalls, accept && is_last, !s_tready, "input not stalled after vector end")
    `LPVD_ASSERT_NOW(a_fin_after_last, fin.valid, $past(lane_ctl_reg.valid && lane_ctl_reg.last), "vector result without a last word")
    `LPVD_ASSERT_NEXT(a_cfg_restart, cfg_wr_en, grp_cnt_reg == '0, "config write did not restart the vector")

endmodule

// ----- hw/rtl/lpvd_lane.sv -----
// One element lane: absolute difference, optional square, registered.
// Depends on lpvd_pkg.
`timescale 1ns / 1ps

module lpvd_lane (
    input  logic                              aclk,
    input  logic signed [lpvd_pkg::ELEM_BITS-1:0] left_in,
    input  logic signed [lpvd_pkg::ELEM_BITS-1:0] right_in,
    input  logic                              lane_en,
    input  logic                              sq_sel,
    output logic [lpvd_pkg::SQ_W-1:0]         lane_val
);

    logic signed [lpvd_pkg::ELEM_BITS:0] diff;
    logic [lpvd_pkg::ELEM_BITS:0]        diff_mag;
    logic [lpvd_pkg::ABS_W-1:0]          abs_val;
    logic [lpvd_pkg::SQ_W-1:0]           lane_val_reg;
    logic [lpvd_pkg::SQ_W-1:0]           lane_val_next;

    assign diff     = {left_in[lpvd_pkg::ELEM_BITS-1], left_in}
                    - {right_in[lpvd_pkg::ELEM_BITS-1], right_in};
    assign diff_mag = diff[lpvd_pkg::ELEM_BITS] ? (~diff + 1'b1) : diff;
    assign abs_val  = diff_mag[lpvd_pkg::ABS_W-1:0];

    always_comb begin
        if (!lane_en) begin
            lane_val_next = '0;
        end else if (sq_sel) begin
            lane_val_next = lpvd_pkg::SQ_W'(abs_val) * lpvd_pkg::SQ_W'(abs_val);
        end else begin
            lane_val_next = lpvd_pkg::SQ_W'(abs_val);
        end
    end

    always_ff @(posedge aclk) begin
        lane_val_reg <= lane_val_next;
    end

    assign lane_val = lane_val_reg;

endmodule

// ----- hw/rtl/lpvd_merge.sv -----
// Merge stage: folds the lane values into the running sum or max,
// checks the abandon bound on full groups. Depends on lpvd_pkg.
`timescale 1ns / 1ps

module lpvd_merge (
    input  logic                                            aclk,
    input  logic                                            aresetn,
    input  logic [lpvd_pkg::LANES-1:0][lpvd_pkg::SQ_W-1:0]  lane_val,
    input  lpvd_pkg::lpvd_item_ctl_t                        ctl,
    input  lpvd_pkg::lpvd_mode_t                            mode,
    input  logic [lpvd_pkg::THR_W-1:0]                      thr,
    input  logic [lpvd_pkg::ACC_W-1:0]                      thr_sq,
    input  logic                                            thr_big,
    output lpvd_pkg::lpvd_fin_t                             fin
);

    logic [lpvd_pkg::ACC_W-1:0] acc_reg, acc_next;
    logic                       abd_reg, abd_next;
    logic                       fin_valid_reg, fin_valid_next;

    logic [lpvd_pkg::ACC_W-1:0] base_acc;
    logic                       base_abd;
    logic [lpvd_pkg::SUM_W-1:0] lane_sum;
    logic [lpvd_pkg::SQ_W-1:0]  lane_max;
    logic [lpvd_pkg::ACC_W:0]   total;
    logic [lpvd_pkg::ACC_W-1:0] upd_acc;
    logic                       over;

    always_comb begin
        lane_sum = '0;
        lane_max = '0;
        for (int i = 0; i < lpvd_pkg::LANES; i++) begin
            lane_sum = lane_sum + lpvd_pkg::SUM_W'(lane_val[i]);
            if (lane_val[i] > lane_max) begin
                lane_max = lane_val[i];
            end
        end
    end

    assign base_acc = ctl.first ? '0 : acc_reg;
    assign base_abd = ctl.first ? 1'b0 : abd_reg;
    assign total    = {1'b0, base_acc} + (lpvd_pkg::ACC_W + 1)'(lane_sum);

    always_comb begin
        if (mode == lpvd_pkg::MODE_MAX) begin
            upd_acc = (lpvd_pkg::ACC_W'(lane_max) > base_acc)
                    ? lpvd_pkg::ACC_W'(lane_max) : base_acc;
        end else if (total[lpvd_pkg::ACC_W]) begin
            upd_acc = '1;   // saturate
        end else begin
            upd_acc = total[lpvd_pkg::ACC_W-1:0];
        end
    end

    // Thresholds too large to square in the accumulator never trip L2.
    always_comb begin
        if (mode == lpvd_pkg::MODE_L2) begin
            over = !thr_big && (upd_acc > thr_sq);
        end else begin
            over = upd_acc > thr;
        end
    end

    always_comb begin
        acc_next       = acc_reg;
        abd_next       = abd_reg;
        fin_valid_next = ctl.valid && ctl.last;
        if (ctl.valid) begin
            acc_next = base_acc;
            abd_next = base_abd;
            if (!base_abd) begin
                acc_next = upd_acc;
                abd_next = ctl.full && over;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_reg       <= '0;
            abd_reg       <= 1'b0;
            fin_valid_reg <= 1'b0;
        end else begin
            acc_reg       <= acc_next;
            abd_reg       <= abd_next;
            fin_valid_reg <= fin_valid_next;
        end
    end

    assign fin.valid     = fin_valid_reg;
    assign fin.abandoned = abd_reg;
    assign fin.value     = acc_reg;

endmodule

// ----- hw/rtl/lpvd_finish.sv -----
// Finisher: per-vector result select, iterative integer square root
// (two bits a cycle) and the output register. Depends on lpvd_pkg.
`timescale 1ns / 1ps
`include "lp_vector_distance_core_defines.svh"

module lpvd_finish (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  lpvd_pkg::lpvd_fin_t               fin,
    input  lpvd_pkg::lpvd_mode_t              mode,
    input  logic [lpvd_pkg::THR_W-1:0]        thr,
    output logic                              busy,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [lpvd_pkg::M_TDATA_W-1:0]    m_tdata,
    output logic                              m_tuser
);

    lpvd_pkg::lpvd_fin_state_t state_reg, state_next;

    logic [lpvd_pkg::ACC_W-1:0]      n_reg;
    logic [lpvd_pkg::ROOT_W+1:0]     rem_reg;
    logic [lpvd_pkg::ROOT_W-1:0]     root_reg;
    logic [lpvd_pkg::ROOT_CNT_W-1:0] cnt_reg;
    logic [lpvd_pkg::DIST_W-1:0]     res_reg;
    logic                            res_abd_reg;
    logic                            out_valid_reg;
    logic [lpvd_pkg::DIST_W-1:0]     out_dist_reg;
    logic                            out_abd_reg;

    logic                            capture;
    logic                            root_step;
    logic                            load_out;
    logic                            need_root;
    logic [lpvd_pkg::ROOT_W+3:0]     rem_shift;
    logic [lpvd_pkg::ROOT_W+3:0]     trial;
    logic                            take;
    logic [lpvd_pkg::ROOT_W+1:0]     rem_next;
    logic [lpvd_pkg::ROOT_W-1:0]     root_next;

    assign need_root = (mode == lpvd_pkg::MODE_L2) && !fin.abandoned;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            lpvd_pkg::FIN_IDLE: begin
                if (fin.valid) begin
                    state_next = need_root ? lpvd_pkg::FIN_ROOT : lpvd_pkg::FIN_HOLD;
                end
            end
            lpvd_pkg::FIN_ROOT: begin
                if (cnt_reg == '0) begin
                    state_next = lpvd_pkg::FIN_HOLD;
                end
            end
            lpvd_pkg::FIN_HOLD: begin
                if (!out_valid_reg || m_tready) begin
                    state_next = lpvd_pkg::FIN_IDLE;
                end
            end
            default: begin
                state_next = lpvd_pkg::FIN_IDLE;
            end
        endcase
    end

    always_comb begin
        capture   = 1'b0;
        root_step = 1'b0;
        load_out  = 1'b0;
        case (state_reg)
            lpvd_pkg::FIN_IDLE: capture   = fin.valid;
            lpvd_pkg::FIN_ROOT: root_step = 1'b1;
            lpvd_pkg::FIN_HOLD: load_out  = !out_valid_reg || m_tready;
            default: begin
                capture = 1'b0;
            end
        endcase
    end

    assign busy = (state_reg != lpvd_pkg::FIN_IDLE);

    // Restoring square root, one result bit per cycle from the top pair down.
    assign rem_shift = {rem_reg, n_reg[lpvd_pkg::ACC_W-1 -: 2]};
    assign trial     = (lpvd_pkg::ROOT_W + 4)'({root_reg, 2'b01});
    assign take      = rem_shift >= trial;
    assign rem_next  = take ? lpvd_pkg::ROOT_W'(0) + (lpvd_pkg::ROOT_W + 2)'(rem_shift - trial)
                            : rem_shift[lpvd_pkg::ROOT_W+1:0];
    assign root_next = {root_reg[lpvd_pkg::ROOT_W-2:0], take};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= lpvd_pkg::FIN_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (load_out) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (capture) begin
            n_reg       <= fin.value;
            rem_reg     <= '0;
            root_reg    <= '0;
            cnt_reg     <= lpvd_pkg::ROOT_CNT_W'(lpvd_pkg::ROOT_W - 1);
            res_abd_reg <= fin.abandoned;
            if (fin.abandoned && (mode == lpvd_pkg::MODE_L2)) begin
                res_reg <= {thr, 1'b0};
            end else begin
                res_reg <= lpvd_pkg::DIST_W'(fin.value);
            end
        end else if (root_step) begin
            n_reg    <= {n_reg[lpvd_pkg::ACC_W-3:0], 2'b00};
            rem_reg  <= rem_next;
            root_reg <= root_next;
            cnt_reg  <= cnt_reg - 1'b1;
            if (cnt_reg == '0) begin
                res_reg <= lpvd_pkg::DIST_W'(root_next);
            end
        end
        if (load_out) begin
            out_dist_reg <= res_reg;
            out_abd_reg  <= res_abd_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = lpvd_pkg::M_TDATA_W'(out_dist_reg);
    assign m_tuser  = out_abd_reg;

    `LPVD_ASSERT_NOW(a_fin_no_collide, fin.valid, state_reg == lpvd_pkg::FIN_IDLE, "finisher busy when a vector result arrived")
    `LPVD_ASSERT_NEXT(a_root_ends, (state_reg == lpvd_pkg::FIN_ROOT) && (cnt_reg == '0), state_reg == lpvd_pkg::FIN_HOLD, "root iteration did not end")
    `LPVD_ASSERT_NEXT(a_hold_loads, load_out, out_valid_reg && (state_reg == lpvd_pkg::FIN_IDLE), "held result not moved to output")

endmodule

// ----- test/tb_lp_vector_distance_core.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for lp_vector_distance_core: streams vector pairs, predicts
// each distance and abandon flag locally and checks them against the result stream.
// Depends on lpvd_pkg and the lp_vector_distance_core RTL.

module tb_lp_vector_distance_core;

    localparam int              CYCLE_LIMIT      = 400_000;
    localparam int              SETTLE_CYCLES    = 40;   // covers the square-root path
    localparam int              SINK_HOLD_CYCLES = 300;
    localparam longint unsigned ACC_FULL         = 64'hFFFF_FFFF_FFFF;

    localparam logic [lpvd_pkg::ELEM_BITS-1:0] E_MIN  = 16'h8000;
    localparam logic [lpvd_pkg::ELEM_BITS-1:0] E_MAX  = 16'h7FFF;
    localparam logic [lpvd_pkg::ELEM_BITS-1:0] E_ZERO = 16'h0000;

    // one input word, packed exactly as s_tdata: left lanes low, threshold high
    typedef struct packed {
        logic [lpvd_pkg::THR_W-1:0]                                 thr;
        logic [lpvd_pkg::LANES-1:0][lpvd_pkg::ELEM_BITS-1:0]        right;
        logic [lpvd_pkg::LANES-1:0][lpvd_pkg::ELEM_BITS-1:0]        left;
    } pair_word_t;

    typedef struct packed {
        logic [lpvd_pkg::DIST_W-1:0] dist_val;
        logic                        abandoned;
    } dist_result_t;

    logic                             aclk;
    logic                             aresetn;
    logic                             cfg_wr_en;
    logic [lpvd_pkg::CFG_ADDR_W-1:0]  cfg_addr;
    logic [lpvd_pkg::CFG_DATA_W-1:0]  cfg_wdata;
    logic                             s_tvalid;
    logic                             s_tready;
    // low to high: left_0..left_3, right_0..right_3, threshold
    logic [lpvd_pkg::S_TDATA_W-1:0]   s_tdata;
    logic                             m_tvalid;
    logic                             m_tready;
    // low to high: distance, zero pad
    logic [lpvd_pkg::M_TDATA_W-1:0]   m_tdata;
    // bit 0: abandoned
    logic                             m_tuser;

    // local copy of the block's configuration and vector state
    lpvd_pkg::lpvd_mode_t             pm_mode = lpvd_pkg::MODE_L1;
    logic [lpvd_pkg::LEN_W-1:0]       pm_len = lpvd_pkg::LEN_RESET;
    longint unsigned                  pm_acc = 0;
    longint unsigned                  pm_thr = 0;
    int                               pm_grp = 0;
    bit                               pm_abandoned = 0;

    dist_result_t           expected_q[$];
    dist_result_t           sink_want;
    int                     err_count = 0;
    bit                     traffic_gaps = 1;
    bit                     sink_hold_req = 0;
    int unsigned            cycle_count = 0;

    lp_vector_distance_core u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    always begin
        aclk = 1'b0;
        #2;
        aclk = 1'b1;
        #2;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Distance predictor
    // ------------------------------------------------------------------
    function automatic int eff_length();
        if (pm_len == 0) return 1;
        if (pm_len > lpvd_pkg::MAX_DIMS) return lpvd_pkg::MAX_DIMS;
        return int'(pm_len);
    endfunction

    function automatic int vector_items();
        return (eff_length() + lpvd_pkg::LANES - 1) / lpvd_pkg::LANES;
    endfunction

    function automatic longint unsigned floor_root(input longint unsigned n);
        longint unsigned r;
        longint unsigned c;
        r = 0;
        for (int b = lpvd_pkg::ROOT_W - 1; b >= 0; b--) begin
            c = r | (64'd1 << b);
            if (c * c <= n) r = c;
        end
        return r;
    endfunction

    task automatic predict_word(input pair_word_t w);
        int              lanes;
        int              d;
        longint unsigned a;
        longint unsigned s;
        bit              over;
        dist_result_t    r;
        if (pm_grp == 0) begin
            pm_thr       = w.thr;
            pm_acc       = 0;
            pm_abandoned = 0;
        end
        lanes = eff_length() - pm_grp * lpvd_pkg::LANES;
        if (lanes > lpvd_pkg::LANES) lanes = lpvd_pkg::LANES;
        if (!pm_abandoned) begin
            for (int i = 0; i < lanes; i++) begin
                d = $signed(w.left[i]) - $signed(w.right[i]);
                a = (d < 0) ? -d : d;
                case (pm_mode)
                    lpvd_pkg::MODE_L1:  s = pm_acc + a;
                    lpvd_pkg::MODE_MAX: s = (a > pm_acc) ? a : pm_acc;
                    default:            s = pm_acc + a * a;
                endcase
                pm_acc = (s > ACC_FULL) ? ACC_FULL : s;
            end
            // bound check only on a full group
            if (lanes == lpvd_pkg::LANES) begin
                if (pm_mode == lpvd_pkg::MODE_L2)
                    over = (pm_thr < (64'd1 << 24)) && (pm_acc > pm_thr * pm_thr);
                else
                    over = pm_acc > pm_thr;
                if (over) pm_abandoned = 1;
            end
        end
        if (pm_grp + 1 >= vector_items()) begin
            r.abandoned = pm_abandoned;
            if (pm_mode == lpvd_pkg::MODE_L2)
                r.dist_val = pm_abandoned ? lpvd_pkg::DIST_W'(2 * pm_thr)
                                          : lpvd_pkg::DIST_W'(floor_root(pm_acc));
            else
                r.dist_val = lpvd_pkg::DIST_W'(pm_acc);
            expected_q.push_back(r);
            pm_grp = 0;
        end else begin
            pm_grp++;
        end
    endtask

    // ------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------
    task automatic write_reg(input logic [lpvd_pkg::CFG_ADDR_W-1:0] idx,
                             input logic [lpvd_pkg::CFG_DATA_W-1:0] val);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        @(negedge aclk);
        if (idx == lpvd_pkg::REG_MODE)
            pm_mode = lpvd_pkg::lpvd_mode_t'(val[lpvd_pkg::MODE_W-1:0]);
        else pm_len = val;
        // any vector in flight is dropped
        pm_grp       = 0;
        pm_acc       = 0;
        pm_thr       = 0;
        pm_abandoned = 0;
    endtask

    task automatic set_mode(input lpvd_pkg::lpvd_mode_t m);
        logic [lpvd_pkg::CFG_DATA_W-1:0] v;
        v = lpvd_pkg::CFG_DATA_W'($urandom);
        v[lpvd_pkg::MODE_W-1:0] = m;
        write_reg(lpvd_pkg::REG_MODE, v);
    endtask

    task automatic set_length(input int len);
        write_reg(lpvd_pkg::REG_LENGTH, lpvd_pkg::CFG_DATA_W'(len));
    endtask

    // entered and left at a falling edge
    task automatic send_word(input pair_word_t w);
        if (traffic_gaps && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(negedge aclk);
        end
        s_tdata  <= lpvd_pkg::S_TDATA_W'(w);
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
        predict_word(w);
        @(negedge aclk);
    endtask

    task automatic wait_results_done();
        s_tvalid <= 1'b0;
        while (expected_q.size() != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    function automatic logic [lpvd_pkg::ELEM_BITS-1:0] pick_elem();
        case ($urandom_range(0, 7))
            0:       return E_MIN;
            1:       return E_MAX;
            2:       return lpvd_pkg::ELEM_BITS'($urandom_range(0, 31)) - 16'd16;
            default: return lpvd_pkg::ELEM_BITS'($urandom);
        endcase
    endfunction

    function automatic logic [lpvd_pkg::THR_W-1:0] pick_threshold();
        logic [lpvd_pkg::THR_W-1:0] r;
        r = lpvd_pkg::THR_W'({$urandom, $urandom});
        case ($urandom_range(0, 5))
            0:       return r;
            1:       return $urandom_range(0, 1) ? '0 : '1;
            2:       return lpvd_pkg::THR_W'(24'hFF_FFFF)
                          + lpvd_pkg::THR_W'($urandom_range(0, 1));
            default: return r >> $urandom_range(8, 47);
        endcase
    endfunction

    function automatic pair_word_t make_word(
        input logic [lpvd_pkg::LANES-1:0][lpvd_pkg::ELEM_BITS-1:0] l,
        input logic [lpvd_pkg::LANES-1:0][lpvd_pkg::ELEM_BITS-1:0] r,
        input logic [lpvd_pkg::THR_W-1:0] thr);
        pair_word_t w;
        w.left  = l;
        w.right = r;
        w.thr   = thr;
        return w;
    endfunction

    function automatic logic [lpvd_pkg::LANES-1:0][lpvd_pkg::ELEM_BITS-1:0] lanes_of(
        input logic [lpvd_pkg::ELEM_BITS-1:0] e0, input logic [lpvd_pkg::ELEM_BITS-1:0] e1,
        input logic [lpvd_pkg::ELEM_BITS-1:0] e2, input logic [lpvd_pkg::ELEM_BITS-1:0] e3);
        return {e3, e2, e1, e0};
    endfunction

    function automatic pair_word_t random_word(input logic [lpvd_pkg::THR_W-1:0] thr);
        pair_word_t w;
        for (int i = 0; i < lpvd_pkg::LANES; i++) begin
            w.left[i]  = pick_elem();
            w.right[i] = pick_elem();
        end
        w.thr = thr;
        return w;
    endfunction

    // bound rides on the first word; later words carry junk in that field
    task automatic send_vector(input int n_words);
        for (int k = 0; k < n_words; k++)
            send_word(random_word(k == 0 ? pick_threshold()
                                         : lpvd_pkg::THR_W'({$urandom, $urandom})));
    endtask

    // ------------------------------------------------------------------
    // Result sink and checker
    // ------------------------------------------------------------------
    initial begin
        m_tready = 1'b0;
        forever begin
            @(negedge aclk);
            if (sink_hold_req) begin
                m_tready <= 1'b0;
                repeat (SINK_HOLD_CYCLES) @(negedge aclk);
                sink_hold_req = 0;
                m_tready <= 1'b1;
            end else if (traffic_gaps && $urandom_range(0, 4) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 3)) @(negedge aclk);
                m_tready <= 1'b1;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_q.size() == 0) begin
                err_count++;
                $display("%0t: unexpected word: expected none, actual distance %0d abandoned %0b",
                         $time, m_tdata[lpvd_pkg::DIST_W-1:0], m_tuser);
            end else begin
                sink_want = expected_q.pop_front();
                if (m_tdata[lpvd_pkg::DIST_W-1:0] !== sink_want.dist_val) begin
                    err_count++;
                    $display("%0t: distance: expected %0d actual %0d",
                             $time, sink_want.dist_val, m_tdata[lpvd_pkg::DIST_W-1:0]);
                end
                if (m_tuser !== sink_want.abandoned) begin
                    err_count++;
                    $display("%0t: abandoned: expected %0b actual %0b",
                             $time, sink_want.abandoned, m_tuser);
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    // L1, length 128 out of reset
    task automatic test_reset_defaults();
        send_vector(vector_items());
        wait_results_done();
    endtask

    task automatic test_directed_corners();
        // length 0 acts as 1: lane 0 only
        set_length(0);
        set_mode(lpvd_pkg::MODE_L1);
        send_word(make_word(lanes_of(E_MAX, E_MIN, E_MIN, E_MIN),
                            lanes_of(E_MIN, E_MAX, E_MAX, E_MAX), '1));
        wait_results_done();

        // max-abs with zero bound abandons; next word has no effect
        set_length(8);
        set_mode(lpvd_pkg::MODE_MAX);
        send_word(make_word(lanes_of(E_MIN, E_ZERO, E_ZERO, E_MAX),
                            lanes_of(E_MAX, E_ZERO, E_ZERO, E_MIN), '0));
        send_word(make_word(lanes_of(E_MAX, E_MAX, E_MAX, E_MAX),
                            lanes_of(E_MIN, E_MIN, E_MIN, E_MIN), '1));
        wait_results_done();

        // L2 bound of 2^24 can never trip; partial group takes lane 0 only
        set_length(5);
        set_mode(lpvd_pkg::MODE_L2);
        send_word(make_word(lanes_of(E_MIN, E_MIN, E_MIN, E_MIN),
                            lanes_of(E_MAX, E_MAX, E_MAX, E_MAX),
                            lpvd_pkg::THR_W'(1) << 24));
        send_word(make_word(lanes_of(E_MAX, E_MIN, E_MIN, E_MIN),
                            lanes_of(E_MIN, E_MAX, E_MAX, E_MAX), '0));
        wait_results_done();

        // bound just below 2^24, squared sum stays under the bound's square
        send_word(make_word(lanes_of(E_MIN, E_MIN, E_MIN, E_MIN),
                            lanes_of(E_MAX, E_MAX, E_MAX, E_MAX),
                            lpvd_pkg::THR_W'(24'hFF_FFFF)));
        send_word(make_word(lanes_of(E_MIN, E_ZERO, E_ZERO, E_ZERO),
                            lanes_of(E_MAX, E_ZERO, E_ZERO, E_ZERO), '0));
        wait_results_done();

        // L2 abandon reports twice the bound
        set_length(11);
        send_word(make_word(lanes_of(E_MAX, E_ZERO, E_ZERO, E_ZERO),
                            lanes_of(E_ZERO, E_ZERO, E_ZERO, E_ZERO),
                            lpvd_pkg::THR_W'(10)));
        send_word(random_word('0));
        send_word(random_word('0));
        wait_results_done();

        // squared L2 at full scale, two-lane tail
        set_mode(lpvd_pkg::MODE_L2SQ);
        set_length(6);
        send_word(make_word(lanes_of(E_MIN, E_MAX, E_MIN, E_MAX),
                            lanes_of(E_MAX, E_MIN, E_MAX, E_MIN), '1));
        send_word(make_word(lanes_of(E_MIN, E_MAX, E_MIN, E_MAX),
                            lanes_of(E_MAX, E_MIN, E_MAX, E_MIN), '0));
        wait_results_done();

        // equal lanes: zero distance does not exceed a zero bound
        set_mode(lpvd_pkg::MODE_L1);
        set_length(4);
        send_word(make_word(lanes_of(E_MIN, E_MAX, E_ZERO, 16'hFFFF),
                            lanes_of(E_MIN, E_MAX, E_ZERO, 16'hFFFF), '0));
        wait_results_done();

        // config write mid-vector drops it without a result
        set_length(12);
        send_vector(2);
        wait_results_done();
        set_mode(lpvd_pkg::MODE_L1);
        send_vector(vector_items());
        wait_results_done();
    endtask

    // 8191 clamps to MAX_DIMS; huge L2 bound keeps the whole vector live
    task automatic test_longest_vector();
        set_mode(lpvd_pkg::MODE_L2);
        set_length(8191);
        for (int k = 0; k < vector_items(); k++)
            send_word(random_word(k == 0 ? '1 : lpvd_pkg::THR_W'({$urandom, $urandom})));
        wait_results_done();
    endtask

    task automatic test_random_phases(input int n_phases);
        lpvd_pkg::lpvd_mode_t m;
        int                   len;
        int                   sent;
        for (int p = 0; p < n_phases; p++) begin
            m = lpvd_pkg::lpvd_mode_t'($urandom_range(0, 3));
            case ($urandom_range(0, 7))
                0:       len = 0;
                1:       len = 1;
                2:       len = lpvd_pkg::LANES;
                default: len = $urandom_range(2, 40);
            endcase
            if ($urandom_range(0, 1)) begin
                set_mode(m);
                set_length(len);
            end else begin
                set_length(len);
                set_mode(m);
            end
            sent = 0;
            while (sent < 40) begin
                send_vector(vector_items());
                sent += vector_items();
            end
            // leave a vector unfinished; the next phase's write drops it
            if ($urandom_range(0, 2) == 0 && vector_items() > 1)
                send_vector($urandom_range(1, vector_items() - 1));
            wait_results_done();
        end
    endtask

    // sink stalls for a long stretch while the bench keeps offering words
    task automatic test_result_backpressure();
        set_mode(lpvd_pkg::MODE_MAX);
        set_length(lpvd_pkg::LANES);
        sink_hold_req = 1;
        for (int k = 0; k < 30; k++)
            send_vector(vector_items());
        wait_results_done();
    endtask

    initial begin
        aresetn   = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        cfg_wr_en = 1'b0;
        cfg_addr  = '0;
        cfg_wdata = '0;
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        test_reset_defaults();
        test_directed_corners();
        test_longest_vector();
        test_random_phases(9);
        test_result_backpressure();
        traffic_gaps = 0;
        test_random_phases(4);

        if (err_count == 0 && expected_q.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
